// ===== src/spfa_pkg.sv =====
package spfa_pkg;

  localparam int unsigned AngleW = 15;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned ErrW = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned LimitW = 15;
  localparam int unsigned CurW = 16;
  localparam int unsigned OutShift = 12;
  localparam int unsigned AccW = LimitW + OutShift + 1;
  localparam int unsigned ProdW = GainW + ErrW + 2;
  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic signed [AngleW+1:0] HalfTurn = 17'sd11520;
  localparam logic signed [AngleW+1:0] FullTurn = 17'sd23040;

  localparam logic [GainW-1:0] PropGainRst = 16'd16384;
  localparam logic [GainW-1:0] IntegGainRst = 16'd52;
  localparam logic [LimitW-1:0] OutLimitRst = 15'd10240;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_TARGET_SPEED = 3'd2,
    REG_OUT_LIMIT    = 3'd3,
    REG_LOOP_ENABLE  = 3'd4
  } cfg_idx_t;

endpackage

// ===== src/speed_pi_from_angle.sv =====
// Channel | Handshake            | Payload
// in      | in_valid, in_ready   | in_angle_sample (request in)
// out     | out_valid, out_ready | out_drive_current, out_measured_speed, out_speed_error
// cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data (register write in)
//
// One request per cycle is accepted while in_ready is high; its result passes through the
// input register, speed/error/product stage and accumulator stage before out_valid rises.
// The accumulator add, clamp and feedback sit alone in the last stage.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
// A stalled result stops the input only once all three stages hold requests.
module speed_pi_from_angle
  import spfa_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [AngleW-1:0]           in_angle_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [CurW-1:0]      out_drive_current,
  output logic signed [SpeedW-1:0]    out_measured_speed,
  output logic signed [ErrW-1:0]      out_speed_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CfgIdxW-1:0]          cfg_index,
  input  logic [CfgDataW-1:0]         cfg_data
);

  logic [GainW-1:0]         prop_gain_r;
  logic [GainW-1:0]         integ_gain_r;
  logic signed [SpeedW-1:0] target_r;
  logic [LimitW-1:0]        limit_r;
  logic                     enable_r;

  logic                     s1_v_r;
  logic [AngleW-1:0]        s1_angle_r;
  logic                     s2_v_r;
  logic signed [SpeedW-1:0] s2_speed_r;
  logic signed [ErrW-1:0]   s2_err_r;
  logic signed [ProdW-1:0]  s2_pprod_r;
  logic signed [ProdW-1:0]  s2_iprod_r;
  logic                     out_v_r;
  logic signed [CurW-1:0]   out_cur_r;
  logic signed [SpeedW-1:0] out_speed_r;
  logic signed [ErrW-1:0]   out_err_r;

  logic [AngleW-1:0]        prev_angle_r;
  logic signed [ErrW-1:0]   prev_err_r;
  logic signed [AccW-1:0]   acc_r;

  logic                     out_free;
  logic                     s2_ld;
  logic                     s1_ld;

  logic signed [AngleW+1:0] diff;
  logic signed [AngleW+1:0] wrapped;
  logic signed [AngleW+1:0] sat;
  logic signed [SpeedW-1:0] speed_nxt;
  logic signed [ErrW-1:0]   err_nxt;
  logic signed [ErrW:0]     derr;
  logic signed [ProdW-1:0]  pprod_nxt;
  logic signed [ProdW-1:0]  iprod_nxt;

  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   lim;
  logic signed [AccW-1:0]   acc_nxt;

  assign out_free = !out_v_r || out_ready;
  assign s2_ld    = !s2_v_r || out_free;
  assign s1_ld    = !s1_v_r || s2_ld;
  assign in_ready = s1_ld;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PropGainRst;
      integ_gain_r <= IntegGainRst;
      target_r     <= '0;
      limit_r      <= OutLimitRst;
      enable_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_PROP_GAIN:    prop_gain_r  <= cfg_data;
        REG_INTEG_GAIN:   integ_gain_r <= cfg_data;
        REG_TARGET_SPEED: target_r     <= cfg_data[SpeedW-1:0];
        REG_OUT_LIMIT:    limit_r      <= cfg_data[LimitW-1:0];
        REG_LOOP_ENABLE:  enable_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff = $signed({2'b00, s1_angle_r}) - $signed({2'b00, prev_angle_r});
    if (diff < -HalfTurn) begin
      wrapped = diff + FullTurn;
    end else if (diff > HalfTurn) begin
      wrapped = diff - FullTurn;
    end else begin
      wrapped = diff;
    end
    if (wrapped > HalfTurn) begin
      sat = HalfTurn;
    end else if (wrapped < -HalfTurn) begin
      sat = -HalfTurn;
    end else begin
      sat = wrapped;
    end
    speed_nxt = sat[SpeedW-1:0];
    err_nxt   = ErrW'(target_r) - ErrW'(speed_nxt);
    derr      = (ErrW+1)'(err_nxt) - (ErrW+1)'(prev_err_r);
    pprod_nxt = ProdW'($signed({1'b0, prop_gain_r}) * derr);
    iprod_nxt = ProdW'($signed({1'b0, integ_gain_r}) * err_nxt);
  end

  always_comb begin
    sum = SumW'(acc_r) + SumW'(s2_pprod_r) + SumW'(s2_iprod_r);
    lim = $signed(SumW'({limit_r, {OutShift{1'b0}}}));
    if (!enable_r) begin
      acc_nxt = '0;
    end else if (sum > lim) begin
      acc_nxt = lim[AccW-1:0];
    end else if (sum < -lim) begin
      acc_nxt = AccW'(-lim);
    end else begin
      acc_nxt = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      prev_angle_r <= '0;
      prev_err_r   <= '0;
      acc_r        <= '0;
    end else begin
      if (s1_ld) begin
        s1_v_r <= in_valid;
      end
      if (s2_ld) begin
        s2_v_r <= s1_v_r;
        if (s1_v_r) begin
          prev_angle_r <= s1_angle_r;
          prev_err_r   <= err_nxt;
        end
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
        if (s2_v_r) begin
          acc_r <= acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      s1_angle_r <= in_angle_sample;
    end
    if (s2_ld && s1_v_r) begin
      s2_speed_r <= speed_nxt;
      s2_err_r   <= err_nxt;
      s2_pprod_r <= pprod_nxt;
      s2_iprod_r <= iprod_nxt;
    end
    if (out_free && s2_v_r) begin
      out_cur_r   <= acc_nxt[AccW-1:OutShift];
      out_speed_r <= s2_speed_r;
      out_err_r   <= s2_err_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_drive_current  = out_cur_r;
  assign out_measured_speed = out_speed_r;
  assign out_speed_error    = out_err_r;

`ifndef SYNTHESIS
  a_disabled_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_free && !enable_r) |=> (acc_r == '0))
    else $error("accumulator not cleared while loop disabled");

  a_prev_angle_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_ld) |=> (prev_angle_r == $past(s1_angle_r)))
    else $error("previous angle not updated on stage advance");

  a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> ((s2_speed_r <= 15'sd11520) && (s2_speed_r >= -15'sd11520)))
    else $error("measured speed outside half turn");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ld) |=> (s1_v_r && $stable(s1_angle_r)))
    else $error("stalled input stage lost its request");
`endif

endmodule
